// File: hw/rtl/utf8_stream_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// shared property wrappers for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// checked property, masked while reset is high
`define U8SD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, live during reset as well
`define U8SD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8 stream decoder package
// field widths and lead byte classification constants
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int BYTE_W   = 8;
   localparam int CP_W     = 21;
   localparam int REMAIN_W = 2;
   localparam int CONT_W   = 6;

   localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
   localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

   localparam logic [REMAIN_W-1:0] REMAIN_NONE  = 2'd0;
   localparam logic [REMAIN_W-1:0] REMAIN_ONE   = 2'd1;
   localparam logic [REMAIN_W-1:0] REMAIN_TWO   = 2'd2;
   localparam logic [REMAIN_W-1:0] REMAIN_THREE = 2'd3;

   typedef logic [CP_W-1:0] code_point_type;

endpackage

// File: hw/rtl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8 stream decoder
// decodes a utf-8 byte stream into code points, while not stalled one byte per cycle
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_ready | req_data_byte, req_end_of_string
//  rsp     | out | rsp_valid / rsp_ready | rsp_code_point, rsp_code_valid,
//          |     |                       | rsp_string_done
//
//  one byte per cycle sustained while rsp_ready holds; an item is held in the
//  input register and decoded into the result register once that is free
//  synchronous active-high reset empties both registers and the decode state
//  a stalled result holds the result register; the input register still takes
//  one more item before req_ready falls
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top
   import u8sd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_end_of_string,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output code_point_type    rsp_code_point,
   output logic              rsp_code_valid,
   output logic              rsp_string_done
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eos_ff;

   // decode state
   logic [REMAIN_W-1:0] remain_ff, remain_in;
   code_point_type      acc_ff, acc_in;

   // result register
   logic           out_valid_ff, out_valid_in;
   code_point_type out_cp_ff, out_cp_in;
   logic           out_cv_ff, out_cv_in;
   logic           out_done_ff, out_done_in;

   logic           out_free, process, req_fire;
   logic           done;
   code_point_type cp_val;
   code_point_type acc_shift;
   logic [REMAIN_W-1:0] remain_dec;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign process   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign acc_shift  = {acc_ff[CP_W-CONT_W-1:0], in_byte_ff[CONT_W-1:0]};
   assign remain_dec = remain_ff - REMAIN_ONE;

   always_comb begin
      done      = 1'b0;
      cp_val    = '0;
      remain_in = remain_ff;
      acc_in    = acc_ff;
      if (process) begin
         priority if (remain_ff != REMAIN_NONE) begin
            // continuation, top bits not checked
            if (remain_ff == REMAIN_ONE) begin
               done      = 1'b1;
               cp_val    = acc_shift;
               acc_in    = '0;
               remain_in = REMAIN_NONE;
            end else begin
               acc_in    = acc_shift;
               remain_in = remain_dec;
            end
         end else if ((in_byte_ff & ASCII_MASK) == '0) begin
            done   = 1'b1;
            cp_val = code_point_type'(in_byte_ff);
         end else if ((in_byte_ff & LEAD2_MASK) == LEAD2_CODE) begin
            acc_in    = code_point_type'(in_byte_ff & LEAD2_BITS);
            remain_in = REMAIN_ONE;
         end else if ((in_byte_ff & LEAD3_MASK) == LEAD3_CODE) begin
            acc_in    = code_point_type'(in_byte_ff & LEAD3_BITS);
            remain_in = REMAIN_TWO;
         end else if ((in_byte_ff & LEAD4_MASK) == LEAD4_CODE) begin
            acc_in    = code_point_type'(in_byte_ff & LEAD4_BITS);
            remain_in = REMAIN_THREE;
         end else begin
            // stray byte, skipped
            remain_in = remain_ff;
         end
         if (in_eos_ff) begin
            // partial sequence dropped at end of string
            remain_in = REMAIN_NONE;
            acc_in    = '0;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_cp_in   = out_cp_ff;
      out_cv_in   = out_cv_ff;
      out_done_in = out_done_ff;
      if (process) begin
         out_valid_in = done || in_eos_ff;
         out_cp_in    = cp_val;
         out_cv_in    = done;
         out_done_in  = in_eos_ff;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remain_ff    <= REMAIN_NONE;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         remain_ff    <= remain_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_string;
      end
      out_cp_ff   <= out_cp_in;
      out_cv_ff   <= out_cv_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_cp_ff;
   assign rsp_code_valid  = out_cv_ff;
   assign rsp_string_done = out_done_ff;

   `U8SD_ASSERT(a_eos_clears_state, clock, reset, process && in_eos_ff |=> remain_ff == REMAIN_NONE && acc_ff == '0, "decode state not cleared after end of string")
   `U8SD_ASSERT(a_idle_acc_zero, clock, reset, remain_ff == REMAIN_NONE |-> acc_ff == '0, "accumulator holds bits with no open sequence")
   `U8SD_ASSERT(a_empty_result_is_eos, clock, reset, rsp_valid && !rsp_code_valid |-> rsp_string_done && rsp_code_point == '0, "result without code point is not an end of string")
   `U8SD_ASSERT(a_state_held_when_idle, clock, reset, !process |=> $stable(remain_ff) && $stable(acc_ff), "decode state moved with no item processed")

endmodule
